@@ hdl/wpg_pkg.sv @@
// ============================================================================
// wpg_pkg - shared definitions for the waveform polyline generator
// Field widths, register indexes, reset values and sequencer states.
// ============================================================================
package wpg_pkg;

    // Default sizing of the top level
    localparam int COUNT_BITS_DEF = 24;
    localparam int COORD_BITS_DEF = 12;

    // Fixed field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int X_BITS         = 13;
    localparam int Y_BITS         = 14;
    localparam int CFG_INDEX_BITS = 3;
    localparam int OUT_DATA_BITS  = 56;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIXTEEN_BIT_MODE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_LEFT        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_TOP         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_WIDTH       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_HEIGHT      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT     = 3'd5;

    // Register reset values
    localparam int AREA_WIDTH_RST   = 640;
    localparam int AREA_HEIGHT_RST  = 256;
    localparam int SAMPLE_COUNT_RST = 1024;

    // Level scaling shifts
    localparam int SHIFT_8BIT  = 8;
    localparam int SHIFT_16BIT = 16;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } wpg_state_t;

endpackage

@@ hdl/waveform_polyline_generator_core.sv @@
// ============================================================================
// waveform_polyline_generator_core - audio samples to plot line segments
// Decimates a frame of samples and emits one segment per changed point.
// ============================================================================
// A sample that is not a plotted point of the frame is skipped in the idle
// state. A plotted sample, and the first sample of every frame, passes
// through these steps: the idle state takes the word, a multiply step
// forms the level product, a shared restoring divider gives one quotient
// bit per cycle, and a final step updates the point. A plotted sample
// whose point moved then goes to an emit step that loads its segment into
// the output register, and stays there for as long as the previous
// segment has not been taken. The divider forms index * width / count
// for x, and at the first sample of a frame count / (width * 256) for the
// decimation step. A segment is offered on the master side from an output
// register; the next sample may be taken while it waits there, and the
// block holds a new segment until the previous one has been taken.
// Configuration words are taken at any time and must only be written while
// the block is idle.
module waveform_polyline_generator_core #(
    parameter int COUNT_BITS = wpg_pkg::COUNT_BITS_DEF,
    parameter int COORD_BITS = wpg_pkg::COORD_BITS_DEF,
    localparam int CFG_DATA_BITS = (COUNT_BITS > COORD_BITS) ? COUNT_BITS : COORD_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wpg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]              cfg_data,
    // Sample stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [wpg_pkg::SAMPLE_BITS-1:0]       s_axis_tdata,  // [15:0] sample_value
    // Segment stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [12:0] start_x, [26:13] start_y, [39:27] end_x, [53:40] end_y, [55:54] zero
    output logic [wpg_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);
    import wpg_pkg::*;

    localparam int DW = COUNT_BITS + COORD_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int PW = SAMPLE_BITS + COORD_BITS + 1;

    // Configuration registers
    logic                  sixteen_bit_mode_reg;
    logic [COORD_BITS-1:0] area_left_reg;
    logic [COORD_BITS-1:0] area_top_reg;
    logic [COORD_BITS-1:0] area_width_reg;
    logic [COORD_BITS-1:0] area_height_reg;
    logic [COUNT_BITS-1:0] sample_count_reg;

    // Frame state
    wpg_state_t            state_reg, state_next;
    logic [COUNT_BITS-1:0] sample_index_reg;
    logic [COUNT_BITS:0]   next_used_reg;
    logic [X_BITS-1:0]     prev_x_reg;
    logic [Y_BITS-1:0]     prev_y_reg;
    logic [COUNT_BITS-1:0] step_size_reg;
    logic                  out_valid_reg;

    // Datapath (no reset)
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic signed [PW-1:0]   yprod_reg;
    logic [Y_BITS-1:0]      y_reg;
    logic [X_BITS-1:0]      x_reg;
    logic [DW-1:0]          quo_reg;
    logic [DW-1:0]          rem_reg;
    logic [DW-1:0]          den_reg;
    logic [CW-1:0]          cnt_reg;
    logic [X_BITS-1:0]      out_sx_reg;
    logic [Y_BITS-1:0]      out_sy_reg;
    logic [X_BITS-1:0]      out_ex_reg;
    logic [Y_BITS-1:0]      out_ey_reg;

    // Combinational helpers
    logic                   s_fire;
    logic                   out_free;
    logic [COUNT_BITS-1:0]  count_eff;
    logic                   first_w;
    logic                   used_w;
    logic                   last_w;
    logic [COUNT_BITS-1:0]  index_adv;
    logic [SAMPLE_BITS-1:0] sample_ext;
    logic signed [PW-1:0]   biased;
    logic signed [PW-1:0]   level_w;
    logic [Y_BITS-1:0]      y_w;
    logic [X_BITS-1:0]      x_w;
    logic                   differ_w;
    logic [DW:0]            trial;
    logic [COUNT_BITS-1:0]  step_w;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Frame position decode
    assign count_eff = (sample_count_reg == '0) ? COUNT_BITS'(1) : sample_count_reg;
    assign first_w   = (sample_index_reg == '0);
    assign used_w    = ({1'b0, sample_index_reg} == next_used_reg);
    assign last_w    = (({1'b0, sample_index_reg} + (COUNT_BITS+1)'(1)) >= {1'b0, count_eff});
    assign index_adv = last_w ? '0 : sample_index_reg + COUNT_BITS'(1);

    // Level and y from the registered product, truncating toward zero
    assign sample_ext = sixteen_bit_mode_reg ? sample_reg
                      : {{(SAMPLE_BITS-8){sample_reg[7]}}, sample_reg[7:0]};
    always_comb
    begin
        biased = yprod_reg;
        if (yprod_reg[PW-1])
        begin
            biased = sixteen_bit_mode_reg ? yprod_reg + PW'((1 << SHIFT_16BIT) - 1)
                                          : yprod_reg + PW'((1 << SHIFT_8BIT) - 1);
        end
        level_w = sixteen_bit_mode_reg ? (biased >>> SHIFT_16BIT) : (biased >>> SHIFT_8BIT);
    end
    assign y_w = Y_BITS'(area_height_reg >> 1) - Y_BITS'(1) - level_w[Y_BITS-1:0]
               + Y_BITS'(area_top_reg);

    // New x and step from the divider quotient
    assign x_w      = quo_reg[X_BITS-1:0] + X_BITS'(area_left_reg);
    assign differ_w = (x_w != prev_x_reg) || (y_reg != prev_y_reg);
    assign step_w   = ((area_width_reg == '0) || (quo_reg == '0)) ? COUNT_BITS'(1)
                    : quo_reg[COUNT_BITS-1:0];

    // Restoring divider trial subtract
    assign trial = {rem_reg, quo_reg[DW-1]} - {1'b0, den_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_fire && (first_w || used_w))
                begin
                    state_next = ST_MUL;
                end
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = ST_FIN;
                end
            ST_FIN:
                state_next = (!first_w && differ_w) ? ST_EMIT : ST_IDLE;
            ST_EMIT:
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        cfg_ready     = 1'b1;
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {2'b00, out_ey_reg, out_ex_reg, out_sy_reg, out_sx_reg};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            sixteen_bit_mode_reg <= 1'b1;
            area_left_reg        <= '0;
            area_top_reg         <= '0;
            area_width_reg       <= COORD_BITS'(AREA_WIDTH_RST);
            area_height_reg      <= COORD_BITS'(AREA_HEIGHT_RST);
            sample_count_reg     <= COUNT_BITS'(SAMPLE_COUNT_RST);
            sample_index_reg     <= '0;
            next_used_reg        <= '0;
            prev_x_reg           <= '0;
            prev_y_reg           <= '0;
            step_size_reg        <= COUNT_BITS'(1);
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Take configuration words
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SIXTEEN_BIT_MODE: sixteen_bit_mode_reg <= cfg_data[0];
                    REG_AREA_LEFT:        area_left_reg        <= cfg_data[COORD_BITS-1:0];
                    REG_AREA_TOP:         area_top_reg         <= cfg_data[COORD_BITS-1:0];
                    REG_AREA_WIDTH:       area_width_reg       <= cfg_data[COORD_BITS-1:0];
                    REG_AREA_HEIGHT:      area_height_reg      <= cfg_data[COORD_BITS-1:0];
                    REG_SAMPLE_COUNT:     sample_count_reg     <= cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end

            // Skip a sample that is not plotted
            if (state_reg == ST_IDLE && s_fire && !first_w && !used_w)
            begin
                sample_index_reg <= index_adv;
            end

            // Update the point, the step and the frame position
            if (state_reg == ST_FIN)
            begin
                sample_index_reg <= index_adv;
                if (first_w)
                begin
                    step_size_reg <= step_w;
                    next_used_reg <= {1'b0, step_w};
                    prev_x_reg    <= X_BITS'(area_left_reg);
                    prev_y_reg    <= y_reg;
                end
                else
                begin
                    next_used_reg <= next_used_reg + {1'b0, step_size_reg};
                end
            end

            // Load a new segment when free, else drop the taken one
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                prev_x_reg    <= x_reg;
                prev_y_reg    <= y_reg;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            sample_reg <= s_axis_tdata;
        end

        unique case (state_reg)
            ST_MUL:
            begin
                // Level product and divider operands
                yprod_reg <= $signed(sample_ext) * $signed({1'b0, area_height_reg});
                rem_reg   <= '0;
                cnt_reg   <= '0;
                if (first_w)
                begin
                    quo_reg <= DW'(count_eff);
                    den_reg <= DW'({area_width_reg, 8'b0});
                end
                else
                begin
                    quo_reg <= DW'(sample_index_reg) * DW'(area_width_reg);
                    den_reg <= DW'(count_eff);
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle
                y_reg   <= y_w;
                cnt_reg <= cnt_reg + CW'(1);
                if (!trial[DW])
                begin
                    rem_reg <= trial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            ST_FIN:
                x_reg <= x_w;
            ST_EMIT:
                if (out_free)
                begin
                    out_sx_reg <= prev_x_reg;
                    out_sy_reg <= prev_y_reg;
                    out_ex_reg <= x_reg;
                    out_ey_reg <= y_reg;
                end
            default: ;
        endcase
    end

    // Checks
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        step_size_reg != '0)
        else $error("step size is zero");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("segment offered outside the emit step");

    a_segment_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_sx_reg != out_ex_reg || out_sy_reg != out_ey_reg))
        else $error("zero-length segment emitted");

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CW'(DW)))
        else $error("divider ran past its last bit");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_MUL) |-> !s_axis_tready)
        else $error("sample taken while a point is being computed");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for waveform_polyline_generator_core
// Streams audio samples into the block under several plot-area settings,
// predicts every line segment in the bench and compares each segment word
// on the master side field by field, with random gaps and stalls.
// ============================================================================
module tb;
    import wpg_pkg::*;

    localparam int CFG_BITS    = COUNT_BITS_DEF;
    localparam int SETTLE_CYC  = 60;           // lets a point finish inside the block
    localparam int TIMEOUT_NS  = 15_000_000;

    typedef struct {
        logic [X_BITS-1:0] start_x;
        logic [Y_BITS-1:0] start_y;
        logic [X_BITS-1:0] end_x;
        logic [Y_BITS-1:0] end_y;
    } segment_t;

    // DUT connections; the bench drives its inputs known from time zero
    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = REG_SIXTEEN_BIT_MODE;
    logic [CFG_BITS-1:0]       cfg_data      = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [SAMPLE_BITS-1:0]    s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;

    // Predicted register copies
    logic                      area_sixteen;
    logic [11:0]               area_left;
    logic [11:0]               area_top;
    logic [11:0]               area_width;
    logic [11:0]               area_height;
    logic [23:0]               frame_count;

    // Predicted decimation and point state
    logic [23:0]               cur_index;
    logic [24:0]               next_plot_index;
    logic [X_BITS-1:0]         last_x;
    logic [Y_BITS-1:0]         last_y;
    logic [23:0]               decim_step;

    segment_t                  pending_segments[$];
    int                        fail_count   = 0;
    logic                      tx_bursty    = 1'b0;
    int                        burst_left   = 0;
    logic                      rx_stalling  = 1'b0;
    int                        rx_left      = 0;
    logic [SAMPLE_BITS-1:0]    last_sample  = '0;

    waveform_polyline_generator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("waveform_polyline_generator_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void reset_prediction();
        area_sixteen    = 1'b1;
        area_left       = '0;
        area_top        = '0;
        area_width      = 12'(AREA_WIDTH_RST);
        area_height     = 12'(AREA_HEIGHT_RST);
        frame_count     = 24'(SAMPLE_COUNT_RST);
        cur_index       = '0;
        next_plot_index = '0;
        last_x          = '0;
        last_y          = '0;
        decim_step      = 24'd1;
    endfunction

    // Scale the sample into the area; division truncates toward zero
    function automatic logic [Y_BITS-1:0] sample_to_y(logic [SAMPLE_BITS-1:0] raw);
        int s;
        int h;
        int lvl;
        int yv;
        h = int'(area_height);
        if (area_sixteen)
        begin
            s   = int'($signed(raw));
            lvl = (s * h) / 65536;
        end
        else
        begin
            s   = int'($signed(raw[7:0]));
            lvl = (s * h) / 256;
        end
        yv = h / 2 - 1 - lvl + int'(area_top);
        return yv[Y_BITS-1:0];
    endfunction

    function automatic logic [X_BITS-1:0] index_to_x(logic [23:0] cnt);
        logic [63:0] xv;
        xv = (64'(cur_index) * 64'(area_width)) / 64'(cnt) + 64'(area_left);
        return xv[X_BITS-1:0];
    endfunction

    // Advance the predicted state by one accepted sample
    function automatic void plot_sample(logic [SAMPLE_BITS-1:0] raw);
        logic [23:0]       cnt;
        logic [Y_BITS-1:0] y;
        logic [X_BITS-1:0] x;
        logic [63:0]       q;
        segment_t          seg;
        cnt = (frame_count == 0) ? 24'd1 : frame_count;
        y   = sample_to_y(raw);
        if (cur_index == 0)
        begin
            // Latch the decimation step and the start point of the frame
            if (area_width == 0)
                q = '0;
            else
                q = 64'(cnt) / (64'(area_width) << 8);
            decim_step      = (q[23:0] == 0) ? 24'd1 : q[23:0];
            last_x          = X_BITS'(area_left);
            last_y          = y;
            next_plot_index = 25'(decim_step);
        end
        else if (25'(cur_index) == next_plot_index)
        begin
            x = index_to_x(cnt);
            // Drop zero-length segments and keep the old point
            if (x != last_x || y != last_y)
            begin
                seg.start_x = last_x;
                seg.start_y = last_y;
                seg.end_x   = x;
                seg.end_y   = y;
                pending_segments.push_back(seg);
                last_x = x;
                last_y = y;
            end
            next_plot_index = next_plot_index + 25'(decim_step);
        end
        if (64'(cur_index) + 64'd1 >= 64'(cnt))
            cur_index = '0;
        else
            cur_index = cur_index + 24'd1;
    endfunction

    // ------------------------------------------------------------------------
    // Segment checking and receiver stalls
    // ------------------------------------------------------------------------
    function automatic void check_segment(logic [OUT_DATA_BITS-1:0] word);
        segment_t exp_seg;
        if (pending_segments.size() == 0)
        begin
            $error("unexpected segment word %h", word);
            fail_count++;
            return;
        end
        exp_seg = pending_segments.pop_front();
        if (word[12:0] !== exp_seg.start_x)
        begin
            $error("start_x expected %0d actual %0d", exp_seg.start_x, word[12:0]);
            fail_count++;
        end
        if (word[26:13] !== exp_seg.start_y)
        begin
            $error("start_y expected %0d actual %0d",
                   $signed(exp_seg.start_y), $signed(word[26:13]));
            fail_count++;
        end
        if (word[39:27] !== exp_seg.end_x)
        begin
            $error("end_x expected %0d actual %0d", exp_seg.end_x, word[39:27]);
            fail_count++;
        end
        if (word[53:40] !== exp_seg.end_y)
        begin
            $error("end_y expected %0d actual %0d",
                   $signed(exp_seg.end_y), $signed(word[53:40]));
            fail_count++;
        end
    endfunction

    // Check each accepted word, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_segment(m_axis_tdata);
        if (!rx_stalling)
            m_axis_tready <= 1'b1;
        else if (rx_left == 0)
        begin
            if (m_axis_tready)
            begin
                m_axis_tready <= 1'b0;
                rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 3);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_left = $urandom_range(1, 16);
            end
        end
        else
            rx_left--;
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------
    // Send one sample word; valid stays high when the burst goes on
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        int gap;
        s_axis_tdata  <= value;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        plot_sample(value);
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45)
                                                  : $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Hold the sender until every predicted segment has arrived
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pending_segments.size() != 0)
            @(posedge clk);
    endtask

    // Also let a point with no segment finish inside the block
    task automatic wait_drain();
        wait_results();
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SIXTEEN_BIT_MODE: area_sixteen = value[0];
            REG_AREA_LEFT:        area_left    = value[11:0];
            REG_AREA_TOP:         area_top     = value[11:0];
            REG_AREA_WIDTH:       area_width   = value[11:0];
            REG_AREA_HEIGHT:      area_height  = value[11:0];
            REG_SAMPLE_COUNT:     frame_count  = value[23:0];
            default: ;
        endcase
    endtask

    // Rewrite every register once the block has gone idle
    task automatic set_area(input logic mode, input logic [11:0] left,
                            input logic [11:0] top, input logic [11:0] width,
                            input logic [11:0] height, input logic [23:0] count);
        wait_drain();
        write_reg(REG_SIXTEEN_BIT_MODE, CFG_BITS'(mode));
        write_reg(REG_AREA_LEFT,        CFG_BITS'(left));
        write_reg(REG_AREA_TOP,         CFG_BITS'(top));
        write_reg(REG_AREA_WIDTH,       CFG_BITS'(width));
        write_reg(REG_AREA_HEIGHT,      CFG_BITS'(height));
        write_reg(REG_SAMPLE_COUNT,     count);
        cfg_valid <= 1'b0;
    endtask

    // Random sample with extremes and occasional repeats
    function automatic logic [SAMPLE_BITS-1:0] next_sample();
        case ($urandom_range(0, 9))
            0:       last_sample = 16'h8000;
            1:       last_sample = 16'h7FFF;
            2:       last_sample = 16'h0000;
            3:       last_sample = 16'hFFFF;
            4:       ;
            default: last_sample = SAMPLE_BITS'($urandom);
        endcase
        return last_sample;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset settings: start point, then full-scale swings
    task automatic test_reset_defaults();
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
    endtask

    // Largest area and offsets, then a one-pixel-high area giving y of -1
    task automatic test_field_extremes();
        set_area(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 24'd4);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'h7FFF);
        set_area(1'b1, 12'd0, 12'd0, 12'd4095, 12'd1, 24'd3);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h1234);
    endtask

    // 8-bit mode ignores the upper byte of the sample
    task automatic test_byte_mode();
        set_area(1'b0, 12'd7, 12'd3, 12'd2, 12'd4095, 24'd4);
        send_sample(16'h7F80);
        send_sample(16'h807F);
        send_sample(16'hFF00);
        send_sample(16'h00FF);
    endtask

    // Repeated point gives no segment, a changed one does
    task automatic test_zero_length();
        set_area(1'b1, 12'd0, 12'd0, 12'd1, 12'd100, 24'd8);
        send_sample(16'h4000);
        send_sample(16'h4000);
        send_sample(16'h4000);
        send_sample(16'hC000);
    endtask

    // Zero width forces a step of one; zero count behaves as one
    task automatic test_degenerate_area();
        set_area(1'b1, 12'd10, 12'd10, 12'd0, 12'd256, 24'd0);
        send_sample(16'h2000);
        send_sample(16'hE000);
        set_area(1'b1, 12'd10, 12'd10, 12'd0, 12'd256, 24'd5);
        send_sample(16'h2000);
        send_sample(16'hE000);
        send_sample(16'h2000);
    endtask

    // Lower the count and height mid-frame so the index wraps early
    task automatic test_count_lowered();
        tx_bursty   = 1'b1;
        rx_stalling = 1'b1;
        set_area(1'b1, 12'd5, 12'd5, 12'd300, 12'd300, 24'd40);
        repeat (20) send_sample(next_sample());
        set_area(1'b1, 12'd5, 12'd5, 12'd300, 12'd200, 24'd8);
        repeat (12) send_sample(next_sample());
    endtask

    // Frames under random plot areas, with a full stop halfway through one
    task automatic test_random_frames();
        logic        mode;
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] width;
        logic [11:0] height;
        logic [23:0] count;
        for (int n = 0; n < 8; n++)
        begin
            mode   = 1'($urandom);
            left   = 12'($urandom);
            top    = 12'($urandom);
            width  = 12'($urandom_range(1, 4095));
            height = 12'($urandom_range(1, 4095));
            count  = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(1, 24'hFFFFFF))
                                                 : 24'($urandom_range(1, 64));
            if (n == 0)
            begin
                left = 12'd4095; top = 12'd4095; width = 12'd4095;
                height = 12'd4095; count = 24'hFFFFFF;
            end
            else if (n == 1)
            begin
                left = 12'd0; top = 12'd0; width = 12'd1; height = 12'd1; count = 24'd2;
            end
            tx_bursty   = n[0];
            rx_stalling = (n != 2);
            set_area(mode, left, top, width, height, count);
            for (int k = 0; k < 40; k++)
            begin
                send_sample(next_sample());
                if (n == 3 && k == 20)
                    wait_results();
            end
        end
    endtask

    // Narrow area over a long frame: every second sample plotted, one wrap
    task automatic test_decimation();
        tx_bursty   = 1'b1;
        rx_stalling = 1'b1;
        set_area(1'b0, 12'd100, 12'd50, 12'd1, 12'd255, 24'd512);
        repeat (530) send_sample(next_sample());
    endtask

    initial
    begin
        reset_prediction();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_field_extremes();
        test_byte_mode();
        test_zero_length();
        test_degenerate_area();
        test_count_lowered();
        test_random_frames();
        test_decimation();
        wait_drain();
        if (fail_count == 0)
            $display("waveform_polyline_generator_core verification clean");
        else
            $display("waveform_polyline_generator_core verification failed");
        $finish;
    end

endmodule
